@@ sv/cbb_pkg.sv @@
// Shared types and constants for the circular byte buffer.
// No dependencies; imported by cbb_ctrl, cbb_datapath and the top level.
package cbb_pkg;

  localparam int ADDR_BITS  = 8;
  localparam int DEPTH      = 1 << ADDR_BITS;
  localparam int SIZE_W     = 4;
  localparam int POS_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(ADDR_BITS);

  // Request opcodes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_RDSLOT = 3'd2;
  localparam logic [2:0] OP_WRSLOT = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_LENGTH = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_POS_ERR = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_CAPTURE = 3'b010,
    S_DONE    = 3'b100
  } state_t;

  typedef struct packed {
    logic load;     // request accepted this cycle
    logic capture;  // result registers take their values
  } cmd_t;

endpackage

@@ sv/cbb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/cbb_ctrl.sv @@
// Controller state machine for the circular byte buffer.
// Depends on cbb_pkg; drives commands into cbb_datapath.
module cbb_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output cbb_pkg::cmd_t cmd
);
  import cbb_pkg::*;

  state_t state, state_next;

  // Advance through accept, capture, deliver
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_CAPTURE;
      S_CAPTURE: state_next = S_DONE;
      S_DONE:    if (!out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake and commands
  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_DONE);
  assign cmd.load    = in_valid && (state == S_IDLE);
  assign cmd.capture = (state == S_CAPTURE);

endmodule

@@ sv/cbb_datapath.sv @@
// Datapath of the circular byte buffer: pointers, size register, byte store
// with per-entry valid bits, and result registers. Depends on cbb_pkg, cbb_ram.
module cbb_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  cbb_pkg::cmd_t               cmd,
  input  logic                        cfg_we,
  input  logic [cbb_pkg::SIZE_W-1:0]  cfg_data,
  input  logic [2:0]                  opcode,
  input  logic [cbb_pkg::BYTE_W-1:0]  write_data,
  input  logic [cbb_pkg::POS_W-1:0]   position,
  output logic [1:0]                  status,
  output logic [cbb_pkg::BYTE_W-1:0]  read_data,
  output logic [cbb_pkg::LEN_W-1:0]   length
);
  import cbb_pkg::*;

  logic [SIZE_W-1:0]    size_log2;
  logic [ADDR_BITS-1:0] rd_ptr, rd_ptr_next;
  logic [ADDR_BITS-1:0] wr_ptr, wr_ptr_next;
  logic [DEPTH-1:0]     vld;
  logic [SIZE_W-1:0]    size_eff;
  logic [ADDR_BITS-1:0] mask;
  logic [ADDR_BITS-1:0] fill;
  logic                 pos_bad;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [BYTE_W-1:0]    ram_q;
  logic                 rd_hit, rd_hit_next;
  logic                 rd_vld;
  logic [1:0]           st, st_next;
  logic                 clr;

  // Effective size, slot mask and fill level
  assign size_eff = (size_log2 > SIZE_W'(ADDR_BITS)) ? SIZE_W'(ADDR_BITS) : size_log2;
  assign mask     = ~({ADDR_BITS{1'b1}} << size_eff);
  assign fill     = (wr_ptr - rd_ptr) & mask;
  assign pos_bad  = position > {{(POS_W-ADDR_BITS){1'b0}}, mask};

  // Decode the request
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    ram_we      = 1'b0;
    ram_waddr   = wr_ptr;
    ram_raddr   = rd_ptr;
    rd_hit_next = 1'b0;
    st_next     = ST_OK;
    clr         = 1'b0;
    unique case (opcode)
      OP_PUSH: begin
        if (fill == mask) begin
          st_next = ST_FULL;
        end else begin
          ram_we      = 1'b1;
          wr_ptr_next = (wr_ptr + 1'b1) & mask;
        end
      end
      OP_POP: begin
        if (fill == '0) begin
          st_next = ST_EMPTY;
        end else begin
          rd_hit_next = 1'b1;
          rd_ptr_next = (rd_ptr + 1'b1) & mask;
        end
      end
      OP_RDSLOT: begin
        ram_raddr = position[ADDR_BITS-1:0];
        if (pos_bad) begin
          st_next = ST_POS_ERR;
        end else begin
          rd_hit_next = 1'b1;
        end
      end
      OP_WRSLOT: begin
        ram_waddr = position[ADDR_BITS-1:0];
        if (pos_bad) begin
          st_next = ST_POS_ERR;
        end else begin
          ram_we = 1'b1;
        end
      end
      OP_CLEAR: begin
        clr         = 1'b1;
        rd_ptr_next = '0;
        wr_ptr_next = '0;
      end
      default: ;
    endcase
  end

  // Control state: size, pointers, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_RESET;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      vld       <= '0;
    end else begin
      if (cfg_we) begin
        size_log2 <= cfg_data;
      end
      if (cmd.load) begin
        rd_ptr <= rd_ptr_next;
        wr_ptr <= wr_ptr_next;
        if (clr) begin
          vld <= '0;
        end else if (ram_we) begin
          vld[ram_waddr] <= 1'b1;
        end
      end
    end
  end

  cbb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load && ram_we),
    .waddr (ram_waddr),
    .wdata (write_data),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Hold request outcome until the read data returns
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_hit <= rd_hit_next;
      rd_vld <= vld[ram_raddr];
      st     <= st_next;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status    <= st;
      read_data <= (rd_hit && rd_vld) ? ram_q : '0;
      length    <= LEN_W'(fill);
    end
  end

endmodule

@@ sv/circular_byte_buffer.sv @@
// Circular byte buffer: power-of-two ring FIFO with slot access, clear, length.
// The controller handles one request at a time and waits for the store's read port;
// it accepts a request, captures its result and holds it until out_stall is low.
// Reset (synchronous, rst high) zeroes pointers and valid bits, size_log2 becomes 8.
// Clear takes effect at once through per-entry valid bits; no sweep.
module circular_byte_buffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  opcode,
  input  logic [cbb_pkg::BYTE_W-1:0]  write_data,
  input  logic [cbb_pkg::POS_W-1:0]   position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [cbb_pkg::BYTE_W-1:0]  read_data,
  output logic [cbb_pkg::LEN_W-1:0]   length,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cbb_pkg::SIZE_W-1:0]  cfg_data
);
  import cbb_pkg::*;

  cmd_t cmd;

  // Size register accepts writes at any time
  assign cfg_ready = 1'b1;

  cbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cbb_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .write_data (write_data),
    .position   (position),
    .status     (status),
    .read_data  (read_data),
    .length     (length)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for circular_byte_buffer: directed and random requests checked against
// a built-in predictor of the ring buffer. Depends on cbb_pkg and the block's RTL.
module tb;
  import cbb_pkg::*;

  // Opcodes the block does not define; they must change nothing
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 1550;
  localparam int SIZE_PHASES = 10;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [1:0]        st;
    logic [BYTE_W-1:0] rdata;
    logic [LEN_W-1:0]  len;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [2:0]        opcode = OP_LENGTH;
  logic [BYTE_W-1:0] write_data = '0;
  logic [POS_W-1:0]  position = '0;
  logic              out_stall = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              in_stall;
  logic              out_valid;
  logic              cfg_ready;
  logic [1:0]        status;
  logic [BYTE_W-1:0] read_data;
  logic [LEN_W-1:0]  length;

  circular_byte_buffer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .write_data (write_data),
    .position   (position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_data  (read_data),
    .length     (length),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the ring: store, pointers and size register
  logic [BYTE_W-1:0] shadow_store [DEPTH];
  logic [7:0]        shadow_rd;
  logic [7:0]        shadow_wr;
  logic [SIZE_W-1:0] shadow_size;

  ring_result_t pending_results [$];
  int           fail_count = 0;
  int           burst_left = 0;

  function automatic logic [7:0] fill_level(input logic [7:0] mask);
    return (shadow_wr - shadow_rd) & mask;
  endfunction

  // Apply one request to the shadow ring and return the result it must produce
  function automatic ring_result_t ring_apply(input logic [2:0] op,
                                              input logic [7:0] wd,
                                              input logic [8:0] pos);
    int unsigned  used_log2;
    int unsigned  slots;
    logic [7:0]   mask;
    ring_result_t res;
    used_log2 = (shadow_size > ADDR_BITS) ? ADDR_BITS : shadow_size;
    slots = 1 << used_log2;
    mask = 8'(slots - 1);
    res = '0;
    res.st = ST_OK;
    case (op)
      OP_PUSH: begin
        if (fill_level(mask) == mask) begin
          res.st = ST_FULL;
        end else begin
          shadow_store[shadow_wr] = wd;
          shadow_wr = (shadow_wr + 8'd1) & mask;
        end
      end
      OP_POP: begin
        if (fill_level(mask) == 8'd0) begin
          res.st = ST_EMPTY;
        end else begin
          res.rdata = shadow_store[shadow_rd];
          shadow_rd = (shadow_rd + 8'd1) & mask;
        end
      end
      OP_RDSLOT: begin
        if (pos >= slots) res.st = ST_POS_ERR;
        else res.rdata = shadow_store[pos[7:0]];
      end
      OP_WRSLOT: begin
        if (pos >= slots) res.st = ST_POS_ERR;
        else shadow_store[pos[7:0]] = wd;
      end
      OP_CLEAR: begin
        shadow_rd = '0;
        shadow_wr = '0;
        foreach (shadow_store[i]) shadow_store[i] = '0;
      end
      default: ;
    endcase
    res.len = fill_level(mask);
    return res;
  endfunction

  // Send one request in bursts with random gaps; predict at acceptance
  task automatic send_request(input logic [2:0] op, input logic [7:0] wd,
                              input logic [8:0] pos);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    opcode <= op;
    write_data <= wd;
    position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(ring_apply(op, wd, pos));
    burst_left--;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_size(input logic [SIZE_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_size = value;
  endtask

  // Check each accepted result and advance the receiver's stall pattern
  int         stall_mode = 0;
  int         mode_left = 0;
  logic [2:0] stall_phase = '0;

  always @(posedge clk) begin
    ring_result_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d read_data %0h length %0d",
               status, read_data, length);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (status !== exp.st) begin
          $error("status: expected %0d, got %0d", exp.st, status);
          fail_count++;
        end
        if (read_data !== exp.rdata) begin
          $error("read_data: expected %0h, got %0h", exp.rdata, read_data);
          fail_count++;
        end
        if (length !== exp.len) begin
          $error("length: expected %0d, got %0d", exp.len, length);
          fail_count++;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= (stall_phase == 3'd4) ? 3'd0 : stall_phase + 3'd1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_phase < 3'd2);
    endcase
  end

  // Buffer right after reset at full size: length, empty pop, slot bounds, spare opcodes
  task automatic test_reset_contents();
    send_request(OP_LENGTH, 8'h00, 9'd0);
    send_request(OP_POP, 8'h00, 9'd0);
    send_request(OP_RDSLOT, 8'h00, 9'd255);
    send_request(OP_RDSLOT, 8'h00, 9'd256);
    send_request(OP_WRSLOT, 8'hFF, 9'd511);
    send_request(OP_WRSLOT, 8'hFF, 9'd255);
    send_request(OP_RDSLOT, 8'h00, 9'd255);
    send_request(OP_SPARE6, 8'hA5, 9'd3);
    send_request(OP_SPARE7, 8'h5A, 9'd300);
  endtask

  // Four slots: fill to full, push once more, drain to empty, pop once more
  task automatic test_fill_and_drain();
    configure_size(4'd2);
    send_request(OP_CLEAR, 8'h00, 9'd0);
    send_request(OP_PUSH, 8'h00, 9'd0);
    send_request(OP_PUSH, 8'hFF, 9'd0);
    send_request(OP_PUSH, 8'h5A, 9'd0);
    send_request(OP_PUSH, 8'h33, 9'd0);
    repeat (3) send_request(OP_POP, 8'h00, 9'd0);
    send_request(OP_POP, 8'h00, 9'd0);
  endtask

  // One slot: push always full, pop always empty, slot 0 read, slot 1 out of range
  task automatic test_single_slot();
    configure_size(4'd0);
    send_request(OP_PUSH, 8'h77, 9'd0);
    send_request(OP_POP, 8'h00, 9'd0);
    send_request(OP_RDSLOT, 8'h00, 9'd0);
    send_request(OP_WRSLOT, 8'h11, 9'd1);
  endtask

  // Size above the store depth is taken as the full depth; after clear, slots read as zero
  task automatic test_oversized_size();
    configure_size(4'd15);
    send_request(OP_WRSLOT, 8'h81, 9'd255);
    send_request(OP_RDSLOT, 8'h00, 9'd256);
    send_request(OP_CLEAR, 8'h00, 9'd0);
    send_request(OP_RDSLOT, 8'h00, 9'd255);
  endtask

  // Runs of pushes and pops with random content at many sizes, plus slot traffic and noise
  task automatic test_random_traffic();
    int         size_plan [SIZE_PHASES] = '{8, 1, 3, 0, 5, 15, 2, 4, 7, 6};
    int         slots;
    int         sent;
    int         run_len;
    int         pick;
    logic [2:0] op;
    logic [8:0] pos;
    foreach (size_plan[p]) begin
      configure_size(SIZE_W'(size_plan[p]));
      slots = 1 << ((size_plan[p] > ADDR_BITS) ? ADDR_BITS : size_plan[p]);
      // Usually clear after a size change; sometimes keep the old pointers
      if ($urandom_range(0, 3) != 0)
        send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      sent = 0;
      while (sent < RANDOM_ITEMS / SIZE_PHASES) begin
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
          if (slots <= 32 || $urandom_range(0, 7) == 0)
            run_len = $urandom_range(1, slots + 1);
          else
            run_len = $urandom_range(1, 24);
          op = (pick <= 2) ? OP_PUSH : OP_POP;
          repeat (run_len) send_request(op, 8'($urandom_range(0, 255)),
                                        9'($urandom_range(0, 511)));
          sent += run_len;
        end else begin
          pos = 9'($urandom_range(0, 511));
          if (pick <= 6) begin
            op = $urandom_range(0, 1) ? OP_RDSLOT : OP_WRSLOT;
            if ($urandom_range(0, 3) != 0) pos = 9'($urandom_range(0, slots - 1));
          end else if (pick == 7) begin
            op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_LENGTH;
          end else begin
            op = 3'($urandom_range(0, 7));
          end
          send_request(op, 8'($urandom_range(0, 255)), pos);
          sent++;
        end
      end
    end
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_rd = '0;
    shadow_wr = '0;
    shadow_size = SIZE_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_contents();
    test_fill_and_drain();
    test_single_slot();
    test_oversized_size();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cbb_pkg.sv
sv/cbb_ram.sv
sv/cbb_ctrl.sv
sv/cbb_datapath.sv
sv/circular_byte_buffer.sv
tb/tb.sv
